// ===== rtl/core/crcdf_pkg.sv =====
package crcdf_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int HDR_LEN     = 7;
    localparam int TRAILER_LEN = 2;
    localparam int BUF_DEPTH   = HDR_LEN + MAX_PAYLOAD + TRAILER_LEN;

    localparam logic [7:0]  MARK_HI   = 8'hA5;
    localparam logic [7:0]  MARK_LO   = 8'h5A;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic CFG_VERSION = 1'b0;
    localparam logic CFG_MAXLEN  = 1'b1;

    localparam logic KIND_DATA = 1'b0;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_APPEND,
        OP_SCAN_INIT,
        OP_SCAN_NEXT,
        OP_SCAN_MISS,
        OP_DROP_START,
        OP_SET_LEN_IDX,
        OP_DROP_TWO,
        OP_CRC_INIT,
        OP_CRC_NEXT,
        OP_CRC_LO,
        OP_DROP_ONE,
        OP_EMIT_INIT,
        OP_EMIT_LOAD,
        OP_EMIT_NEXT,
        OP_DROP_FRAME
    } t_dp_op;

    typedef struct packed {
        logic cnt_zero;
        logic marker_hit;
        logic scan_end;
        logic short_hdr;
        logic len_bad;
        logic short_frame;
        logic crc_end;
        logic crc_ok;
        logic out_ack;
        logic out_last;
    } t_dp_status;

    // Ring index: a sum of two in-range indexes stays below twice the depth.
    function automatic logic [5:0] wrap(input logic [6:0] a);
        logic [6:0] r;
        r = (a >= 7'(BUF_DEPTH)) ? a - 7'(BUF_DEPTH) : a;
        return r[5:0];
    endfunction

    // One byte of CRC-16/Modbus, bit by bit, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crcdf_dp.sv =====
module crcdf_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crcdf_pkg::t_dp_op     i_op,
    output crcdf_pkg::t_dp_status o_status,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic [7:0]            o_frame_type,
    output logic [15:0]           o_sequence_number,
    output logic [5:0]            o_payload_length,
    output logic [4:0]            o_payload_index,
    output logic [7:0]            o_payload_byte,
    output logic                  o_last
);

    logic [7:0]  r_mem [0:crcdf_pkg::BUF_DEPTH-1];
    logic [7:0]  r_rdata;
    logic [5:0]  r_head, n_head;
    logic [5:0]  r_cnt, n_cnt;
    logic [5:0]  r_idx, n_idx;
    logic        r_prev_a5, n_prev_a5;
    logic [15:0] r_crc, n_crc;
    logic [5:0]  r_len, n_len;
    logic [7:0]  r_got_lo, n_got_lo;
    logic [7:0]  r_ver, n_ver;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_seq, n_seq;
    logic [7:0]  r_proto;
    logic [5:0]  r_maxlen;
    logic        r_o_valid, n_o_valid;
    logic [4:0]  r_o_index, n_o_index;
    logic [7:0]  r_o_byte, n_o_byte;
    logic        r_o_last, n_o_last;

    logic [5:0]  rd_addr;
    logic [5:0]  wr_addr;
    logic [5:0]  lim;
    logic [6:0]  fsize_rd;
    logic [6:0]  fsize;
    logic        item_last;
    logic [5:0]  drop_n;
    logic        do_drop;

    assign rd_addr  = crcdf_pkg::wrap({1'b0, r_head} + {1'b0, r_idx});
    assign wr_addr  = crcdf_pkg::wrap({1'b0, r_head} + {1'b0, r_cnt});
    assign lim      = (r_maxlen > 6'(crcdf_pkg::MAX_PAYLOAD)) ? 6'(crcdf_pkg::MAX_PAYLOAD)
                                                              : r_maxlen;
    assign fsize_rd = 7'(r_rdata[5:0]) + 7'(crcdf_pkg::HDR_LEN + crcdf_pkg::TRAILER_LEN);
    assign fsize    = 7'(r_len) + 7'(crcdf_pkg::HDR_LEN + crcdf_pkg::TRAILER_LEN);
    assign item_last = (r_len == 6'd0) ||
                       ({1'b0, r_idx} == 7'(r_len) + 7'(crcdf_pkg::HDR_LEN - 1));

    always_comb begin
        o_status.cnt_zero    = (r_cnt == 6'd0);
        o_status.marker_hit  = r_prev_a5 && (r_rdata == crcdf_pkg::MARK_LO);
        o_status.scan_end    = (r_idx + 6'd1 == r_cnt);
        o_status.short_hdr   = (r_cnt < 6'(crcdf_pkg::HDR_LEN));
        o_status.len_bad     = (r_rdata > {2'b00, lim});
        o_status.short_frame = ({1'b0, r_cnt} < fsize_rd);
        o_status.crc_end     = ({1'b0, r_idx} + 7'd1 == 7'(r_len) + 7'(crcdf_pkg::HDR_LEN));
        o_status.crc_ok      = ({r_rdata, r_got_lo} == r_crc) && (r_ver == r_proto);
        o_status.out_ack     = r_o_valid && i_ready;
        o_status.out_last    = r_o_last;
    end

    always_comb begin
        drop_n  = 6'd0;
        do_drop = 1'b0;
        unique case (i_op)
            crcdf_pkg::OP_DROP_START: begin
                drop_n  = r_idx - 6'd1;
                do_drop = 1'b1;
            end
            crcdf_pkg::OP_DROP_TWO: begin
                drop_n  = 6'd2;
                do_drop = 1'b1;
            end
            crcdf_pkg::OP_DROP_ONE: begin
                drop_n  = 6'd1;
                do_drop = 1'b1;
            end
            crcdf_pkg::OP_DROP_FRAME: begin
                drop_n  = fsize[5:0];
                do_drop = 1'b1;
            end
            default: begin
                drop_n  = 6'd0;
                do_drop = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_prev_a5 = r_prev_a5;
        n_crc     = r_crc;
        n_len     = r_len;
        n_got_lo  = r_got_lo;
        n_ver     = r_ver;
        n_type    = r_type;
        n_seq     = r_seq;
        n_o_valid = r_o_valid && !i_ready;
        n_o_index = r_o_index;
        n_o_byte  = r_o_byte;
        n_o_last  = r_o_last;
        if (do_drop) begin
            n_head = crcdf_pkg::wrap({1'b0, r_head} + {1'b0, drop_n});
            n_cnt  = r_cnt - drop_n;
        end
        unique case (i_op)
            crcdf_pkg::OP_APPEND: begin
                if (r_cnt == 6'(crcdf_pkg::BUF_DEPTH)) begin
                    n_head = crcdf_pkg::wrap({1'b0, r_head} + 7'd1);
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            crcdf_pkg::OP_SCAN_INIT: begin
                n_idx     = 6'd0;
                n_prev_a5 = 1'b0;
            end
            crcdf_pkg::OP_SCAN_NEXT: begin
                n_idx     = r_idx + 6'd1;
                n_prev_a5 = (r_rdata == crcdf_pkg::MARK_HI);
            end
            crcdf_pkg::OP_SCAN_MISS: begin
                // A trailing A5 may open the next marker, so it stays.
                if (r_rdata == crcdf_pkg::MARK_HI) begin
                    n_head = crcdf_pkg::wrap({1'b0, r_head} + {1'b0, r_cnt - 6'd1});
                    n_cnt  = 6'd1;
                end else begin
                    n_cnt = 6'd0;
                end
            end
            crcdf_pkg::OP_SET_LEN_IDX: begin
                n_idx = 6'd4;
            end
            crcdf_pkg::OP_CRC_INIT: begin
                n_idx = 6'd0;
                n_crc = crcdf_pkg::CRC_INIT;
                n_len = r_rdata[5:0];
            end
            crcdf_pkg::OP_CRC_NEXT: begin
                n_crc = crcdf_pkg::crc_byte(r_crc, r_rdata);
                n_idx = r_idx + 6'd1;
                case (r_idx)
                    6'd2:    n_ver        = r_rdata;
                    6'd3:    n_type       = r_rdata;
                    6'd5:    n_seq[15:8]  = r_rdata;
                    6'd6:    n_seq[7:0]   = r_rdata;
                    default: n_ver        = r_ver;
                endcase
            end
            crcdf_pkg::OP_CRC_LO: begin
                n_got_lo = r_rdata;
                n_idx    = r_idx + 6'd1;
            end
            crcdf_pkg::OP_EMIT_INIT: begin
                n_idx = 6'(crcdf_pkg::HDR_LEN);
            end
            crcdf_pkg::OP_EMIT_LOAD: begin
                n_o_valid = 1'b1;
                n_o_index = 5'(r_idx - 6'(crcdf_pkg::HDR_LEN));
                n_o_byte  = (r_len == 6'd0) ? 8'h00 : r_rdata;
                n_o_last  = item_last;
            end
            crcdf_pkg::OP_EMIT_NEXT: begin
                n_idx = r_idx + 6'd1;
            end
            default: begin
                n_idx = n_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= 6'd0;
            r_cnt     <= 6'd0;
            r_idx     <= 6'd0;
            r_prev_a5 <= 1'b0;
            r_proto   <= 8'd1;
            r_maxlen  <= 6'd32;
            r_o_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
            r_prev_a5 <= n_prev_a5;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    crcdf_pkg::CFG_VERSION: r_proto  <= i_cfg_wdata;
                    crcdf_pkg::CFG_MAXLEN:  r_maxlen <= i_cfg_wdata[5:0];
                    default:                r_proto  <= r_proto;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc     <= n_crc;
        r_len     <= n_len;
        r_got_lo  <= n_got_lo;
        r_ver     <= n_ver;
        r_type    <= n_type;
        r_seq     <= n_seq;
        r_o_index <= n_o_index;
        r_o_byte  <= n_o_byte;
        r_o_last  <= n_o_last;
        r_rdata   <= r_mem[rd_addr];
        if (i_op == crcdf_pkg::OP_APPEND) begin
            r_mem[(r_cnt == 6'(crcdf_pkg::BUF_DEPTH)) ? r_head : wr_addr] <= i_rx_byte;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_frame_type      = r_type;
    assign o_sequence_number = r_seq;
    assign o_payload_length  = r_len;
    assign o_payload_index   = r_o_index;
    assign o_payload_byte    = r_o_byte;
    assign o_last            = r_o_last;

endmodule

// ===== rtl/core/crcdf_ctrl.sv =====
module crcdf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_kind,
    output logic                  o_ready,
    input  crcdf_pkg::t_dp_status i_status,
    output crcdf_pkg::t_dp_op     o_op
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SCAN_REQ, S_SCAN_USE, S_HDR_CHK,
        S_LEN_REQ, S_LEN_USE, S_CRC_REQ, S_CRC_USE,
        S_LO_REQ, S_LO_USE, S_HI_REQ, S_HI_USE,
        S_OUT_REQ, S_OUT_USE, S_OUT_WAIT
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = crcdf_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = (i_kind == crcdf_pkg::KIND_DATA) ? crcdf_pkg::OP_APPEND
                                                               : crcdf_pkg::OP_NONE;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_status.cnt_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_op    = crcdf_pkg::OP_SCAN_INIT;
                    n_state = S_SCAN_REQ;
                end
            end
            S_SCAN_REQ: n_state = S_SCAN_USE;
            S_SCAN_USE: begin
                if (i_status.marker_hit) begin
                    o_op    = crcdf_pkg::OP_DROP_START;
                    n_state = S_HDR_CHK;
                end else if (i_status.scan_end) begin
                    o_op    = crcdf_pkg::OP_SCAN_MISS;
                    n_state = S_IDLE;
                end else begin
                    o_op    = crcdf_pkg::OP_SCAN_NEXT;
                    n_state = S_SCAN_REQ;
                end
            end
            S_HDR_CHK: begin
                if (i_status.short_hdr) begin
                    n_state = S_IDLE;
                end else begin
                    o_op    = crcdf_pkg::OP_SET_LEN_IDX;
                    n_state = S_LEN_REQ;
                end
            end
            S_LEN_REQ: n_state = S_LEN_USE;
            S_LEN_USE: begin
                if (i_status.len_bad) begin
                    o_op    = crcdf_pkg::OP_DROP_TWO;
                    n_state = S_START;
                end else if (i_status.short_frame) begin
                    n_state = S_IDLE;
                end else begin
                    o_op    = crcdf_pkg::OP_CRC_INIT;
                    n_state = S_CRC_REQ;
                end
            end
            S_CRC_REQ: n_state = S_CRC_USE;
            S_CRC_USE: begin
                o_op    = crcdf_pkg::OP_CRC_NEXT;
                n_state = i_status.crc_end ? S_LO_REQ : S_CRC_REQ;
            end
            S_LO_REQ: n_state = S_LO_USE;
            S_LO_USE: begin
                o_op    = crcdf_pkg::OP_CRC_LO;
                n_state = S_HI_REQ;
            end
            S_HI_REQ: n_state = S_HI_USE;
            S_HI_USE: begin
                if (i_status.crc_ok) begin
                    o_op    = crcdf_pkg::OP_EMIT_INIT;
                    n_state = S_OUT_REQ;
                end else begin
                    o_op    = crcdf_pkg::OP_DROP_ONE;
                    n_state = S_START;
                end
            end
            S_OUT_REQ: n_state = S_OUT_USE;
            S_OUT_USE: begin
                o_op    = crcdf_pkg::OP_EMIT_LOAD;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_status.out_ack) begin
                    if (i_status.out_last) begin
                        o_op    = crcdf_pkg::OP_DROP_FRAME;
                        n_state = S_IDLE;
                    end else begin
                        o_op    = crcdf_pkg::OP_EMIT_NEXT;
                        n_state = S_OUT_REQ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/crc16_frame_deframer_top.sv =====
// Each item is taken in, then the buffered bytes are scanned for the marker, and a frame's
// header, CRC and trailer bytes are read one by one; each result beat waits out any output
// stall. Every buffer read goes through the buffer memory's single registered read port.
// One item is worked on at a time.
// Reset (synchronous, active low) empties the buffer and sets version 1, max length 32.
module crc16_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_sequence_number,
    output logic [5:0]  o_payload_length,
    output logic [4:0]  o_payload_index,
    output logic [7:0]  o_payload_byte,
    output logic        o_last
);

    crcdf_pkg::t_dp_op     op;
    crcdf_pkg::t_dp_status status;

    crcdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .o_ready  (o_ready),
        .i_status (status),
        .o_op     (op)
    );

    crcdf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_rx_byte         (i_rx_byte),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_frame_type      (o_frame_type),
        .o_sequence_number (o_sequence_number),
        .o_payload_length  (o_payload_length),
        .o_payload_index   (o_payload_index),
        .o_payload_byte    (o_payload_byte),
        .o_last            (o_last)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [7:0]  ftype;
        logic [15:0] seq;
        logic [5:0]  plen;
        logic [4:0]  pidx;
        logic [7:0]  pbyte;
        logic        last;
    } t_beat;

    // Predicts the deframer and holds the payload beats still to come.
    class frame_scoreboard;
        logic [7:0] buf_q[$];
        logic [7:0] version;
        logic [5:0] max_len;
        t_beat      pending[$];
        int         n_errors;
        int         n_frames;
        int         n_beats;

        function void reset_state();
            buf_q.delete();
            version = 8'd1;
            max_len = 6'd32;
        endfunction

        function void drop(int n);
            repeat (n) if (buf_q.size() > 0) void'(buf_q.pop_front());
        endfunction

        function logic [15:0] crc_of(int len);
            logic [15:0] c;
            c = crcdf_pkg::CRC_INIT;
            for (int i = 0; i < len; i++) begin
                c ^= {8'h00, buf_q[i]};
                for (int k = 0; k < 8; k++)
                    c = c[0] ? ((c >> 1) ^ crcdf_pkg::CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void note_input(logic kind, logic [7:0] b);
            int lim;
            int start;
            int len;
            int fsize;
            int n;
            logic [15:0] got;
            t_beat e;
            lim = (max_len > crcdf_pkg::MAX_PAYLOAD) ? crcdf_pkg::MAX_PAYLOAD : max_len;
            if (kind == crcdf_pkg::KIND_DATA) begin
                if (buf_q.size() >= crcdf_pkg::BUF_DEPTH) drop(1);
                buf_q.push_back(b);
            end
            forever begin
                start = -1;
                for (int i = 0; i + 1 < buf_q.size(); i++)
                    if (buf_q[i] == crcdf_pkg::MARK_HI && buf_q[i+1] == crcdf_pkg::MARK_LO) begin
                        start = i;
                        break;
                    end
                if (start < 0) begin
                    if (buf_q.size() > 0 && buf_q[$] == crcdf_pkg::MARK_HI) begin
                        buf_q.delete();
                        buf_q.push_back(crcdf_pkg::MARK_HI);
                    end else buf_q.delete();
                    return;
                end
                drop(start);
                if (buf_q.size() < crcdf_pkg::HDR_LEN) return;
                len = buf_q[4];
                if (len > lim) begin
                    drop(2);
                    continue;
                end
                fsize = crcdf_pkg::HDR_LEN + len + crcdf_pkg::TRAILER_LEN;
                if (buf_q.size() < fsize) return;
                got = {buf_q[fsize-1], buf_q[fsize-2]};
                if (got != crc_of(crcdf_pkg::HDR_LEN + len) || buf_q[2] != version) begin
                    drop(1);
                    continue;
                end
                n = (len == 0) ? 1 : len;
                for (int i = 0; i < n; i++) begin
                    e.ftype = buf_q[3];
                    e.seq   = {buf_q[5], buf_q[6]};
                    e.plen  = len[5:0];
                    e.pidx  = i[4:0];
                    e.pbyte = (len == 0) ? 8'h00 : buf_q[crcdf_pkg::HDR_LEN + i];
                    e.last  = (i + 1 == n);
                    pending.push_back(e);
                end
                n_frames++;
                drop(fsize);
                return;
            end
        endfunction

        function void check_beat(t_beat a);
            t_beat e;
            n_beats++;
            if (pending.size() == 0) begin
                $error("unexpected beat: type %h seq %h", a.ftype, a.seq);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            if (a.ftype !== e.ftype) begin
                $error("frame_type exp %h got %h", e.ftype, a.ftype); n_errors++;
            end
            if (a.seq !== e.seq) begin
                $error("sequence_number exp %h got %h", e.seq, a.seq); n_errors++;
            end
            if (a.plen !== e.plen) begin
                $error("payload_length exp %0d got %0d", e.plen, a.plen); n_errors++;
            end
            if (a.pidx !== e.pidx) begin
                $error("payload_index exp %0d got %0d", e.pidx, a.pidx); n_errors++;
            end
            if (a.pbyte !== e.pbyte) begin
                $error("payload_byte exp %h got %h", e.pbyte, a.pbyte); n_errors++;
            end
            if (a.last !== e.last) begin
                $error("last exp %b got %b", e.last, a.last); n_errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_frame_type;
    logic [15:0] o_sequence_number;
    logic [5:0]  o_payload_length;
    logic [4:0]  o_payload_index;
    logic [7:0]  o_payload_byte;
    logic        o_last;

    crc16_frame_deframer_top dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    frame_scoreboard sb = new();
    int  idle_pct = 34;
    int  hold_off = 0;
    int  quiet = 0;
    int  items_sent = 0;
    int  polls_sent = 0;

    // Output side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        t_beat a;
        if (i_rst_n && o_valid && i_ready) begin
            a.ftype = o_frame_type;
            a.seq   = o_sequence_number;
            a.plen  = o_payload_length;
            a.pidx  = o_payload_index;
            a.pbyte = o_payload_byte;
            a.last  = o_last;
            sb.check_beat(a);
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else i_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Valid stays high between back-to-back beats; it drops only while idling.
    task automatic send_item(logic kind, logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(kind, b);
        items_sent++;
        if (kind != crcdf_pkg::KIND_DATA) polls_sent++;
    endtask

    task automatic push_frame(logic [7:0] ver, logic [7:0] ftype, int len,
                              logic [15:0] seq, bit corrupt);
        logic [7:0] f[$];
        logic [15:0] c;
        f = '{crcdf_pkg::MARK_HI, crcdf_pkg::MARK_LO, ver, ftype, 8'(len),
              seq[15:8], seq[7:0]};
        for (int i = 0; i < len; i++) f.push_back(8'($urandom));
        c = crcdf_pkg::CRC_INIT;
        foreach (f[i]) begin
            c ^= {8'h00, f[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ crcdf_pkg::CRC_POLY) : (c >> 1);
        end
        if (corrupt) c ^= 16'(1 << $urandom_range(15));
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        foreach (f[i]) send_item(crcdf_pkg::KIND_DATA, f[i]);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (sb.pending.size() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        // A dropped frame can leave the block rescanning with nothing owed.
        repeat (400) @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic addr, logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == crcdf_pkg::CFG_VERSION) sb.version = v;
        else sb.max_len = v[5:0];
    endtask

    task automatic random_traffic(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 60)
                push_frame(($urandom_range(9) == 0) ? 8'($urandom) : sb.version,
                           8'($urandom),
                           ($urandom_range(9) == 0) ? $urandom_range(33)
                                                    : $urandom_range(5),
                           16'($urandom), $urandom_range(7) == 0);
            else if (r < 80) send_item(crcdf_pkg::KIND_DATA, 8'($urandom));
            else if (r < 90)
                send_item(crcdf_pkg::KIND_DATA,
                          ($urandom_range(1) != 0) ? crcdf_pkg::MARK_HI : crcdf_pkg::MARK_LO);
            else send_item(~crcdf_pkg::KIND_DATA, 8'($urandom));
        end
    endtask

    initial begin
        sb.reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty payload, longest payload, a leading partial marker,
        // bad CRC, wrong version, a poll.
        push_frame(8'd1, 8'h00, 0, 16'h0000, 0);
        send_item(crcdf_pkg::KIND_DATA, crcdf_pkg::MARK_HI);
        push_frame(8'd1, 8'hFF, 32, 16'hFFFF, 0);
        push_frame(8'd1, 8'h12, 3, 16'h8001, 1);
        push_frame(8'd2, 8'h34, 2, 16'h0102, 0);
        send_item(~crcdf_pkg::KIND_DATA, 8'hFF);
        push_frame(8'd1, 8'h56, 1, 16'h7FFE, 0);
        drain();

        write_reg(crcdf_pkg::CFG_VERSION, 8'hFF);
        write_reg(crcdf_pkg::CFG_MAXLEN, 8'd0);
        push_frame(8'hFF, 8'hAA, 1, 16'h5555, 0);
        push_frame(8'hFF, 8'h55, 0, 16'hAAAA, 0);
        drain();

        write_reg(crcdf_pkg::CFG_VERSION, 8'h00);
        write_reg(crcdf_pkg::CFG_MAXLEN, 8'd63);
        push_frame(8'h00, 8'h01, 33, 16'h1234, 0);
        push_frame(8'h00, 8'h02, 4, 16'h4321, 0);
        drain();

        write_reg(crcdf_pkg::CFG_VERSION, 8'd1);
        write_reg(crcdf_pkg::CFG_MAXLEN, 8'd32);
        idle_pct = 0;
        random_traffic(3);
        idle_pct = 34;
        random_traffic(3);
        // Long receiver hold-off while a good frame is owed and items keep arriving.
        push_frame(8'd1, 8'h77, 4, 16'h0F0F, 0);
        hold_off = 300;
        random_traffic(3);
        drain();

        write_reg(crcdf_pkg::CFG_VERSION, 8'h5A);
        write_reg(crcdf_pkg::CFG_MAXLEN, 8'd4);
        random_traffic(3);
        drain();

        write_reg(crcdf_pkg::CFG_VERSION, 8'hA5);
        write_reg(crcdf_pkg::CFG_MAXLEN, 8'd20);
        random_traffic(3);
        drain();

        $display("Sent %0d items (%0d polls); %0d frames, %0d payload beats checked.",
                 items_sent, polls_sent, sb.n_frames, sb.n_beats);
        if (sb.pending.size() > 0) begin
            $error("%0d beats never arrived", sb.pending.size());
            sb.n_errors++;
        end
        if (sb.n_errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
